### design/dswd_pkg.sv
// Shared types and constants for the distinct symbol window detector.
// No dependencies.
`default_nettype none

package dswd_pkg;

  localparam int unsigned SymW = 8;
  localparam int unsigned PosW = 16;
  localparam int unsigned RunW = 5;
  localparam int unsigned CfgW = 5;

  localparam logic [CfgW-1:0] WindowReset = CfgW'(14);
  localparam logic [PosW-1:0] PosMax      = {PosW{1'b1}};

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            message_start;
  } in_t;

  typedef struct packed {
    logic            marker_found;
    logic [PosW-1:0] symbol_position;
    logic [RunW-1:0] distinct_run;
    logic            message_done;
  } out_t;

  // Sequencer to tracker commands.
  typedef struct packed {
    logic lookup;     // read last-seen slot for sym
    logic start;      // new message: empty the run
    logic probe;      // read ring at the last-seen slot
    logic commit;     // write back ring and last-seen, advance slot
    logic clear_run;  // with commit: marker hit, empty the run
  } ctrl_t;

endpackage

`default_nettype wire

### design/dswd_tracker.sv
// Run tracker: last-seen slot table and symbol ring, both synchronous memories.
// Depends on dswd_pkg.
`default_nettype none

module dswd_tracker #(
  parameter int unsigned MaxWindow = 16,
  localparam int unsigned CntW = $clog2(MaxWindow + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dswd_pkg::ctrl_t         ctrl_i,
  input  wire logic [dswd_pkg::SymW-1:0] sym_i,
  output logic [CntW-1:0]              run_len_o
);

  localparam int unsigned SlotW = $clog2(MaxWindow);
  localparam int unsigned SymDepth = 2 ** dswd_pkg::SymW;

  logic [SlotW-1:0]          last_mem [SymDepth];
  logic [dswd_pkg::SymW-1:0] ring_mem [MaxWindow];

  logic [SlotW-1:0]          last_q;
  logic [dswd_pkg::SymW-1:0] ring_q;
  logic [SlotW-1:0]          slot_q, slot_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [CntW-1:0]           count_next;
  logic [SlotW:0]            diff, age;
  logic                      hit;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lookup) begin
      last_q <= last_mem[sym_i];
    end
    if (ctrl_i.commit) begin
      last_mem[sym_i] <= slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.probe) begin
      ring_q <= ring_mem[last_q];
    end
    if (ctrl_i.commit) begin
      ring_mem[slot_q] <= sym_i;
    end
  end

  // Age of the last occurrence, modulo the ring depth. It is a real hit only
  // when it lies inside the run and the ring still holds the same symbol there;
  // that check also screens stale or never-written last-seen entries.
  always_comb begin
    diff = {1'b0, slot_q} - {1'b0, last_q};
    if (diff[SlotW]) begin
      age = diff + (SlotW + 1)'(MaxWindow);
    end else begin
      age = diff;
    end
    hit = 1'b0;
    if (({1'b0, last_q} < (SlotW + 1)'(MaxWindow)) && (age != '0) &&
        (age <= (SlotW + 1)'(count_q)) && (ring_q == sym_i)) begin
      hit = 1'b1;
    end
    if (hit) begin
      count_next = CntW'(age);
    end else if (count_q == CntW'(MaxWindow)) begin
      count_next = count_q;  // full run: oldest symbol falls out
    end else begin
      count_next = count_q + 1'b1;
    end
  end

  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    if (ctrl_i.start) begin
      count_d = '0;
    end else if (ctrl_i.commit) begin
      count_d = ctrl_i.clear_run ? '0 : count_next;
    end
    if (ctrl_i.commit) begin
      slot_d = (slot_q == SlotW'(MaxWindow - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      count_q <= '0;
    end else begin
      slot_q  <= slot_d;
      count_q <= count_d;
    end
  end

  assign run_len_o = count_next;

endmodule

`default_nettype wire

### design/distinct_symbol_window_detector.sv
// Distinct symbol window detector top level: handshakes, sequencer, output register.
// Depends on dswd_pkg and dswd_tracker.
//
//   port        dir  handshake                 payload
//   in_*        in   in_valid_i / in_ready_o   dswd_pkg::in_t
//   out_*       out  out_valid_o / out_ready_i dswd_pkg::out_t
//   cfg_*       in   cfg_we_i (no wait)        window length, 5 bits
//
// A transaction steps through last-seen table read, ring read, then
// compare and write-back; the next symbol is taken only once it is done.
// A finished result sits in the output register while the next transaction
// is taken; the write-back stalls only while that register is still full.
// Reset clears the run, position and found flag and sets the window length to 14;
// memory contents need no clearing.
`default_nettype none

module distinct_symbol_window_detector #(
  parameter int unsigned MaxWindow = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire dswd_pkg::in_t             in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output dswd_pkg::out_t                 out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [dswd_pkg::CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam int unsigned CmpW = (CntW > dswd_pkg::CfgW) ? CntW : dswd_pkg::CfgW;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_CHECK = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [dswd_pkg::CfgW-1:0]   win_q;
  logic [dswd_pkg::PosW-1:0]   pos_q, pos_d, pos_base;
  logic                        found_q, found_d;
  logic                        done_q;
  logic [dswd_pkg::SymW-1:0]   sym_q;
  logic                        out_valid_q, out_valid_d;
  dswd_pkg::out_t              out_q, out_d;

  dswd_pkg::ctrl_t             ctrl;
  logic [dswd_pkg::SymW-1:0]   trk_sym;
  logic [CntW-1:0]             run_len;
  logic [CmpW-1:0]             win_ext, win_eff, run_ext;
  logic                        accept, out_free, marker;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Window length clamped to 1..MaxWindow.
  always_comb begin
    win_ext = CmpW'(win_q);
    if (win_q == '0) begin
      win_eff = CmpW'(1);
    end else if (win_ext > CmpW'(MaxWindow)) begin
      win_eff = CmpW'(MaxWindow);
    end else begin
      win_eff = win_ext;
    end
  end

  assign run_ext = CmpW'(run_len);
  assign marker  = !done_q && (run_ext == win_eff);

  always_comb begin
    ctrl.lookup    = accept;
    ctrl.start     = accept && in_data_i.message_start;
    ctrl.probe     = (state_q == S_PROBE);
    ctrl.commit    = (state_q == S_CHECK) && out_free && !done_q;
    ctrl.clear_run = marker;
  end

  assign trk_sym = accept ? in_data_i.symbol : sym_q;

  dswd_tracker #(
    .MaxWindow(MaxWindow)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sym_i    (trk_sym),
    .run_len_o(run_len)
  );

  always_comb begin
    pos_base = in_data_i.message_start ? '0 : pos_q;
    pos_d    = (pos_base == dswd_pkg::PosMax) ? pos_base : pos_base + 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_PROBE;
          if (in_data_i.message_start) begin
            found_d = 1'b0;
          end
        end
      end
      S_PROBE: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (out_free) begin
          state_d                   = S_IDLE;
          out_valid_d               = 1'b1;
          out_d.marker_found        = marker;
          out_d.symbol_position     = pos_q;
          out_d.distinct_run        = done_q ? '0 : run_ext[dswd_pkg::RunW-1:0];
          out_d.message_done        = done_q;
          if (marker) begin
            found_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_q       <= dswd_pkg::WindowReset;
      pos_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      sym_q  <= in_data_i.symbol;
      done_q <= found_q && !in_data_i.message_start;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### sim/dswd_tb_pkg.sv
`timescale 1ns / 1ps
// Marker checker for the distinct symbol window detector testbench: predicts one
// report per symbol and compares it with what the block returns. Depends on dswd_pkg.

package dswd_tb_pkg;

  localparam int unsigned RunDepth = 16;

  class marker_checker;
    logic [dswd_pkg::SymW-1:0] held_syms [RunDepth];
    int unsigned               held_len;
    logic [dswd_pkg::PosW-1:0] position;
    bit                        found;
    logic [dswd_pkg::CfgW-1:0] window_reg;
    dswd_pkg::out_t            due_reports[$];
    int unsigned               mismatches;

    function new();
      held_len   = 0;
      position   = '0;
      found      = 1'b0;
      window_reg = dswd_pkg::WindowReset;
      mismatches = 0;
    endfunction

    function void set_window(logic [dswd_pkg::CfgW-1:0] value);
      window_reg = value;
    endfunction

    // 0 behaves as 1, anything past the run depth as the run depth
    function int unsigned effective_window();
      if (window_reg == 0) return 1;
      if (window_reg > RunDepth) return RunDepth;
      return 32'(window_reg);
    endfunction

    function void drop_front(int unsigned n);
      if (n >= held_len) begin
        held_len = 0;
        return;
      end
      for (int unsigned i = n; i < held_len; i++) held_syms[i - n] = held_syms[i];
      held_len -= n;
    endfunction

    // Notes an accepted symbol and queues the report it should produce.
    function void take_symbol(dswd_pkg::in_t item);
      dswd_pkg::out_t rep;
      int             hit;
      rep = '0;
      if (item.message_start) begin
        held_len = 0;
        position = '0;
        found    = 1'b0;
      end
      if (position != dswd_pkg::PosMax) position++;
      rep.symbol_position = position;
      if (found) begin
        rep.message_done = 1'b1;
        rep.distinct_run = held_len[dswd_pkg::RunW-1:0];
      end else begin
        hit = -1;
        for (int i = 0; i < int'(held_len); i++) begin
          if (hit < 0 && held_syms[i] == item.symbol) hit = i;
        end
        if (hit >= 0) drop_front(unsigned'(hit + 1));
        if (held_len >= RunDepth) drop_front(1);
        held_syms[held_len] = item.symbol;
        held_len++;
        rep.distinct_run = held_len[dswd_pkg::RunW-1:0];
        if (held_len == effective_window()) begin
          rep.marker_found = 1'b1;
          found            = 1'b1;
          held_len         = 0;
        end
      end
      due_reports.push_back(rep);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want !== got) begin
        $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(dswd_pkg::out_t got);
      dswd_pkg::out_t want;
      if (due_reports.size() == 0) begin
        $display("%0t ns: report expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("marker_found", 32'(want.marker_found), 32'(got.marker_found));
      compare_field("symbol_position", 32'(want.symbol_position),
                    32'(got.symbol_position));
      compare_field("distinct_run", 32'(want.distinct_run), 32'(got.distinct_run));
      compare_field("message_done", 32'(want.message_done), 32'(got.message_done));
    endfunction
  endclass

endpackage

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for distinct_symbol_window_detector: directed and random messages,
// window changes, backpressure. Depends on dswd_pkg, dswd_tb_pkg and the RTL.

module tb_top;

  localparam int unsigned SymW = dswd_pkg::SymW;

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      in_valid  = 1'b0;
  dswd_pkg::in_t             in_data   = '0;
  logic                      in_ready;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  dswd_pkg::out_t            out_data;
  logic                      cfg_we    = 1'b0;
  logic [dswd_pkg::CfgW-1:0] cfg_wdata = '0;

  dswd_tb_pkg::marker_checker chk = new();
  bit                         tx_gaps = 1'b0;
  bit                         rx_gaps = 1'b0;
  int unsigned                rx_hold = 0;
  int unsigned                sent_count = 0;

  distinct_symbol_window_detector #(
    .MaxWindow(dswd_tb_pkg::RunDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // mostly back to back, some short pauses, a few long ones
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_symbol(input logic [SymW-1:0] sym, input logic start);
    int unsigned   gap;
    dswd_pkg::in_t item;
    gap = tx_gaps ? pause_len() : 0;
    item.symbol        = sym;
    item.message_start = start;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    chk.take_symbol(item);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (chk.due_reports.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_window(input logic [dswd_pkg::CfgW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    chk.set_window(value);
  endtask

  // Messages with random content; one that marks ends at most three symbols after its marker.
  task automatic run_messages(input int unsigned goal);
    int unsigned     w;
    int unsigned     mode;
    int unsigned     len;
    int unsigned     tail;
    logic [SymW-1:0] base;
    logic [SymW-1:0] sym;
    sent_count = 0;
    while (sent_count < goal) begin
      w    = chk.effective_window();
      mode = $urandom_range(0, 9);
      base = SymW'($urandom);
      len  = $urandom_range(1, 3 * w + 6);
      tail = $urandom_range(0, 3);
      for (int unsigned k = 0; k < len && sent_count < goal; k++) begin
        if (mode < 4) sym = SymW'($urandom);
        else if (mode < 8) sym = base + SymW'($urandom_range(0, w));
        else sym = base ^ SymW'($urandom_range(0, 3));
        send_symbol(sym, k == 0 || $urandom_range(0, 49) == 0);
        if (chk.found) begin
          if (tail == 0) break;
          tail--;
        end
      end
    end
  endtask

  initial begin : rx_side
    int unsigned stall;
    bit          rdy;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rdy = 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        rdy = 1'b0;
        stall--;
      end else if (rx_gaps) begin
        stall = pause_len();
        rdy   = (stall == 0);
        if (stall > 0) stall--;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) chk.check_report(out_data);
  end

  initial begin : stimulus
    logic [dswd_pkg::CfgW-1:0] plan [10];
    plan = '{5'd14, 5'd2, 5'd16, 5'd31, 5'd1, 5'd5, 5'd17, 5'd8, 5'd0, 5'd11};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // window left at its reset length of 14
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);  // repeats the oldest held symbol
    for (int k = 1; k <= 12; k++) send_symbol(SymW'(k), 1'b0);
    send_symbol(8'hFF, 1'b0);  // message already marked, ignored
    send_symbol(8'hFF, 1'b1);

    // zero window acts as one: every fresh message marks on its first symbol
    write_window('0);
    send_symbol(8'h80, 1'b1);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h7F, 1'b1);

    foreach (plan[i]) begin
      write_window(plan[i]);
      tx_gaps = (i % 3 != 1);
      rx_gaps = (i % 4 != 2);
      if (i == 5) begin
        // receiver holds off while symbols keep coming until the input stalls
        tx_gaps = 1'b0;
        rx_hold = 300;
      end
      run_messages(145);
    end

    // message opening on a 15-symbol alphabet with the full window, so no marker there; then random symbols
    write_window(5'd16);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_symbol(SymW'($urandom_range(0, 14)), 1'b1);
    for (int k = 0; k < 60; k++) send_symbol(SymW'($urandom_range(0, 14)), 1'b0);
    for (int k = 0; k < 20; k++) send_symbol(SymW'($urandom), 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    if (chk.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(8_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
